FILE: rtl/grt_pkg.sv
package grt_pkg;

  localparam int CRIT_W    = 24;
  localparam int FRAC_W    = 16;
  localparam int WHOLE_W   = CRIT_W - FRAC_W;
  localparam int HUND_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int THR_W     = 24;
  localparam int LIM_W     = 31;

  // 0.01 in Q0.16.
  localparam logic signed [HUND_W-1:0] ONE_HUNDREDTH = HUND_W'(655);

  localparam logic [CRIT_W-1:0] CRIT_MAX   = {CRIT_W{1'b1}};
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(52429);
  localparam logic [LIM_W-1:0]  LIM_RESET  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_SMALL_LIMIT = 2'd1
  } cfg_reg_e;

endpackage

FILE: rtl/grt_if.sv
interface grt_cell_if #(
  parameter int VB = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [VB-1:0] center_value;
  logic signed [VB-1:0] minus_x;
  logic signed [VB-1:0] plus_x;
  logic signed [VB-1:0] minus_y;
  logic signed [VB-1:0] plus_y;
  logic signed [VB-1:0] minus_z;
  logic signed [VB-1:0] plus_z;
  logic                 covered;

  modport source (output valid, center_value, minus_x, plus_x, minus_y, plus_y,
                  minus_z, plus_z, covered, input ready);
  modport sink   (input valid, center_value, minus_x, plus_x, minus_y, plus_y,
                  minus_z, plus_z, covered, output ready);
endinterface

interface grt_result_if;
  import grt_pkg::*;
  logic              valid;
  logic              ready;
  logic              tag_set;
  logic [CRIT_W-1:0] criterion;

  modport source (output valid, tag_set, criterion, input ready);
  modport sink   (input valid, tag_set, criterion, output ready);
endinterface

interface grt_cfg_if;
  import grt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/grt_front.sv
module grt_front import grt_pkg::*; #(
  parameter int DIM = 3,
  parameter int VB  = 32,
  parameter int DW  = VB + 3,
  parameter int RW  = DW + FRAC_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [LIM_W-1:0]             small_limit_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VB-1:0]         center_i,
  input  logic [DIM-1:0][VB-1:0]       minus_i,
  input  logic [DIM-1:0][VB-1:0]       plus_i,
  input  logic                         covered_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DIM-1:0][RW-1:0]       rem_o,
  output logic [DIM-1:0][DW-1:0]       den_o,
  output logic [DIM-1:0]               zero_o,
  output logic [DIM-1:0]               sat_o,
  output logic                         covered_o
);

  localparam int PW = DW + HUND_W;

  logic                         s1_valid_q;
  logic                         s1_adv;
  logic                         s2_adv;
  logic signed [DIM-1:0][DW-1:0] a_d, a_q;
  logic [DIM-1:0][DW-1:0]        sabs_d, sabs_q;
  logic signed [DIM-1:0][PW-1:0] wprod_d, wprod_q;
  logic                          cov1_q;

  logic                          s2_valid_q;
  logic [DIM-1:0][RW-1:0]        rem_d, rem_q;
  logic [DIM-1:0][DW-1:0]        den_d, den_q;
  logic [DIM-1:0]                zero_d, zero_q, sat_d, sat_q;
  logic                          cov2_q;

  assign s2_adv     = !s2_valid_q || out_ready_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;

  always_comb begin
    logic signed [DW-1:0] c, m, p, d1, d2, s;
    logic [DW-1:0]        abs1, abs2;
    c = DW'(center_i);
    for (int d = 0; d < DIM; d++) begin
      m = DW'($signed(minus_i[d]));
      p = DW'($signed(plus_i[d]));
      a_d[d]     = p - (c <<< 1) + m;
      d1         = p - c;
      d2         = c - m;
      abs1       = d1[DW-1] ? DW'(-d1) : DW'(d1);
      abs2       = d2[DW-1] ? DW'(-d2) : DW'(d2);
      sabs_d[d]  = abs1 + abs2;
      s          = p + (c <<< 1) + m;
      wprod_d[d] = PW'(s) * PW'(ONE_HUNDREDTH);
    end
  end

  always_comb begin
    logic signed [PW-1:0] fl;
    logic signed [DW:0]   b;
    logic [DW-1:0]        bm, anum;
    for (int d = 0; d < DIM; d++) begin
      // Arithmetic shift gives the floor of the weighted sum.
      fl        = $signed(wprod_q[d]) >>> FRAC_W;
      b         = $signed({1'b0, sabs_q[d]}) + (DW+1)'(fl);
      bm        = b[DW] ? DW'(-b) : DW'(b);
      anum      = a_q[d][DW-1] ? DW'(-a_q[d]) : DW'(a_q[d]);
      den_d[d]  = bm;
      zero_d[d] = (DW+LIM_W)'(bm) <= (DW+LIM_W)'(small_limit_i);
      sat_d[d]  = (DW+WHOLE_W)'(anum) >= {bm, {WHOLE_W{1'b0}}};
      rem_d[d]  = {anum, {FRAC_W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_valid_i;
      if (s2_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && in_valid_i) begin
      a_q     <= a_d;
      sabs_q  <= sabs_d;
      wprod_q <= wprod_d;
      cov1_q  <= covered_i;
    end
    if (s2_adv && s1_valid_q) begin
      rem_q  <= rem_d;
      den_q  <= den_d;
      zero_q <= zero_d;
      sat_q  <= sat_d;
      cov2_q <= cov1_q;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign rem_o       = rem_q;
  assign den_o       = den_q;
  assign zero_o      = zero_q;
  assign sat_o       = sat_q;
  assign covered_o   = cov2_q;

endmodule

FILE: rtl/grt_div_cell.sv
module grt_div_cell import grt_pkg::*; #(
  parameter int DIM = 3,
  parameter int DW  = 35,
  parameter int RW  = DW + FRAC_W,
  parameter int K   = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [DIM-1:0][RW-1:0] rem_i,
  input  logic [DIM-1:0][DW-1:0] den_i,
  input  logic [DIM-1:0][CRIT_W-1:0] q_i,
  input  logic [DIM-1:0]         zero_i,
  input  logic [DIM-1:0]         sat_i,
  input  logic                   covered_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DIM-1:0][RW-1:0] rem_o,
  output logic [DIM-1:0][DW-1:0] den_o,
  output logic [DIM-1:0][CRIT_W-1:0] q_o,
  output logic [DIM-1:0]         zero_o,
  output logic [DIM-1:0]         sat_o,
  output logic                   covered_o
);

  localparam int TW = DW + CRIT_W;

  logic                       valid_q;
  logic                       adv;
  logic [DIM-1:0][RW-1:0]     rem_d, rem_q;
  logic [DIM-1:0][DW-1:0]     den_q;
  logic [DIM-1:0][CRIT_W-1:0] q_d, q_q;
  logic [DIM-1:0]             zero_q, sat_q;
  logic                       cov_q;

  assign adv        = !valid_q || out_ready_i;
  assign in_ready_o = adv;

  // One restoring step: quotient bit K of each lane.
  always_comb begin
    logic [TW-1:0] trial, rext;
    for (int d = 0; d < DIM; d++) begin
      trial = TW'(den_i[d]) << K;
      rext  = TW'(rem_i[d]);
      q_d[d] = q_i[d];
      if (rext >= trial) begin
        rem_d[d]  = RW'(rext - trial);
        q_d[d][K] = 1'b1;
      end else begin
        rem_d[d] = rem_i[d];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      q_q    <= q_d;
      zero_q <= zero_i;
      sat_q  <= sat_i;
      cov_q  <= covered_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rem_o       = rem_q;
  assign den_o       = den_q;
  assign q_o         = q_q;
  assign zero_o      = zero_q;
  assign sat_o       = sat_q;
  assign covered_o   = cov_q;

endmodule

FILE: rtl/gradient_refinement_tagger.sv
// Gradient refinement tagger: a second-derivative error estimator per grid cell.
// Input channel cell_i carries one cell per item: the center value, the two
// neighbors on each axis (only the first DIMENSIONS axes are used) and a
// covered flag. Output channel result_o returns one item per cell, in order:
// the largest axis ratio |a|/|b| as unsigned Q8.16 (saturated) and a tag bit
// that is set when it reaches the threshold register. Covered cells give zero.
// Configuration channel cfg_i writes threshold (index 0) and small_limit
// (index 1); it is always ready and should be used only while the block is
// empty. Other indexes are ignored.
// A cell passes two front stages, one divider cell per quotient bit (24) and
// the output register before its result is valid.
// Throughput is one item per cycle while result_o is ready. Every stage has
// its own valid bit and takes new data whenever it is empty or its successor
// moves, so a stall at result_o fills empty stages first and only then holds
// off cell_i. Reset empties the pipeline and loads the register defaults.
module gradient_refinement_tagger import grt_pkg::*; #(
  parameter int DIMENSIONS = 3,
  parameter int VALUE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  grt_cell_if.sink      cell_i,
  grt_result_if.source  result_o,
  grt_cfg_if.sink       cfg_i
);

  localparam int DIM = DIMENSIONS;
  localparam int VB  = VALUE_BITS;
  localparam int DW  = VB + 3;
  localparam int RW  = DW + FRAC_W;

  logic [THR_W-1:0] threshold_q;
  logic [LIM_W-1:0] small_limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= THR_RESET;
      small_limit_q <= LIM_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_THRESHOLD:   threshold_q   <= cfg_i.data[THR_W-1:0];
        REG_SMALL_LIMIT: small_limit_q <= cfg_i.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [2:0][VB-1:0]     all_minus, all_plus;
  logic [DIM-1:0][VB-1:0] minus_w, plus_w;

  assign all_minus = {cell_i.minus_z, cell_i.minus_y, cell_i.minus_x};
  assign all_plus  = {cell_i.plus_z, cell_i.plus_y, cell_i.plus_x};
  assign minus_w   = all_minus[DIM-1:0];
  assign plus_w    = all_plus[DIM-1:0];

  logic                       c_valid [CRIT_W+1];
  logic                       c_ready [CRIT_W+1];
  logic [DIM-1:0][RW-1:0]     c_rem   [CRIT_W+1];
  logic [DIM-1:0][DW-1:0]     c_den   [CRIT_W+1];
  logic [DIM-1:0][CRIT_W-1:0] c_q     [CRIT_W+1];
  logic [DIM-1:0]             c_zero  [CRIT_W+1];
  logic [DIM-1:0]             c_sat   [CRIT_W+1];
  logic                       c_cov   [CRIT_W+1];

  assign c_q[0] = '0;

  grt_front #(.DIM(DIM), .VB(VB), .DW(DW), .RW(RW)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .small_limit_i (small_limit_q),
    .in_valid_i    (cell_i.valid),
    .in_ready_o    (cell_i.ready),
    .center_i      (cell_i.center_value),
    .minus_i       (minus_w),
    .plus_i        (plus_w),
    .covered_i     (cell_i.covered),
    .out_valid_o   (c_valid[0]),
    .out_ready_i   (c_ready[0]),
    .rem_o         (c_rem[0]),
    .den_o         (c_den[0]),
    .zero_o        (c_zero[0]),
    .sat_o         (c_sat[0]),
    .covered_o     (c_cov[0])
  );

  // Cell i produces quotient bit CRIT_W-1-i, most significant first.
  for (genvar i = 0; i < CRIT_W; i++) begin : g_cell
    grt_div_cell #(.DIM(DIM), .DW(DW), .RW(RW), .K(CRIT_W-1-i)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c_valid[i]),
      .in_ready_o  (c_ready[i]),
      .rem_i       (c_rem[i]),
      .den_i       (c_den[i]),
      .q_i         (c_q[i]),
      .zero_i      (c_zero[i]),
      .sat_i       (c_sat[i]),
      .covered_i   (c_cov[i]),
      .out_valid_o (c_valid[i+1]),
      .out_ready_i (c_ready[i+1]),
      .rem_o       (c_rem[i+1]),
      .den_o       (c_den[i+1]),
      .q_o         (c_q[i+1]),
      .zero_o      (c_zero[i+1]),
      .sat_o       (c_sat[i+1]),
      .covered_o   (c_cov[i+1])
    );
  end

  logic              out_valid_q;
  logic              out_tag_q;
  logic [CRIT_W-1:0] out_crit_q;
  logic              out_cov_q;
  logic              out_adv;
  logic [CRIT_W-1:0] best_d;
  logic              tag_d;

  assign out_adv          = !out_valid_q || result_o.ready;
  assign c_ready[CRIT_W]  = out_adv;

  always_comb begin
    logic [CRIT_W-1:0] lane;
    best_d = '0;
    for (int d = 0; d < DIM; d++) begin
      if (c_zero[CRIT_W][d]) lane = '0;
      else if (c_sat[CRIT_W][d]) lane = CRIT_MAX;
      else lane = c_q[CRIT_W][d];
      if (lane > best_d) best_d = lane;
    end
    if (c_cov[CRIT_W]) best_d = '0;
    tag_d = !c_cov[CRIT_W] && (best_d >= threshold_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= c_valid[CRIT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && c_valid[CRIT_W]) begin
      out_tag_q  <= tag_d;
      out_crit_q <= best_d;
      out_cov_q  <= c_cov[CRIT_W];
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.tag_set   = out_tag_q;
  assign result_o.criterion = out_crit_q;

  a_tag_meets_threshold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_tag_q) |-> (out_crit_q >= threshold_q))
    else $error("tag set below threshold");

  a_covered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_cov_q) |-> (out_crit_q == '0 && !out_tag_q))
    else $error("covered cell gave a nonzero result");

  a_empty_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !c_valid[CRIT_W]) |-> c_ready[CRIT_W-1])
    else $error("last cell stalled with empty output stage");

endmodule
